[design/maws_pkg.sv]
`default_nettype none
package maws_pkg;

	localparam int MAX_ARRAYS = 16;
	localparam int MAX_LEN    = 256;

	// id, element index and length widths follow from the bank geometry
	localparam int ID_W   = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
	localparam int CNT_W  = $clog2(MAX_ARRAYS + 1);
	localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = ID_W + IDX_W;
	localparam int MEM_DEPTH = 2 ** ADDR_W;

	localparam int OP_W    = 3;
	localparam int AID_W   = 8;
	localparam int EIDX_W  = 12;
	localparam int WORD_W  = 32;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 40;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
	localparam logic [OP_W-1:0] OP_SIZE   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	typedef struct packed {
		logic load_req;   // capture the accepted request
		logic exec;       // perform the request and load the result
		logic rd_issue;   // start an element read
		logic out_ram;    // load the result from the read data
		logic fill_start; // point the fill counter at the old length
		logic fill_step;  // zero one skipped entry
	} cmd_t;

	typedef struct packed {
		logic read_go;    // read request that hits a stored element
		logic fill_go;    // accepted write that needs a zero fill first
		logic fill_done;  // fill counter has reached the write index
	} stat_t;

endpackage
`default_nettype wire

[design/multi_array_word_store_core.sv]
// Each accepted request is registered, then its result is loaded into the output register
// from the EXEC state once the output slot is free; a read first passes the RDWAIT state for
// the element store port, and a growing write first zero-fills its skipped entries in the FILL
// state through the single port. A new item is taken only once the last result has been loaded.
// Reset clears the allocation count and all lengths at once; the element store is not
// cleared, and no entry can be read before a value or a zero fill has written it.
`default_nettype none
module multi_array_word_store_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// op[2:0], array_id[10:3], element_index[22:11], write_value[54:23], zero[55]
	input  wire logic [maws_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// result_word[31:0], status_ok[32], zero[39:33]
	output logic      [maws_pkg::OUT_W-1:0]  m_axis_tdata
);
	import maws_pkg::*;

	cmd_t              cmd;
	stat_t             st;
	logic [WORD_W-1:0] result_word;
	logic              status_ok;

	maws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	maws_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.op           (s_axis_tdata[2:0]),
		.array_id     (s_axis_tdata[10:3]),
		.element_index(s_axis_tdata[22:11]),
		.write_value  (s_axis_tdata[54:23]),
		.result_word  (result_word),
		.status_ok    (status_ok)
	);

	assign m_axis_tdata = {{(OUT_W-WORD_W-1){1'b0}}, status_ok, result_word};

	// a rejected item always carries a zero word
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == '0)
		else $error("rejected item with nonzero result word");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec || cmd.out_ram) && m_axis_tvalid |-> m_axis_tready)
		else $error("result loaded over a waiting item");

	// the output slot stays empty while a zero fill runs
	a_fill_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> !m_axis_tvalid)
		else $error("output busy during zero fill");

	// a new result appears only after a load command
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.exec || cmd.out_ram))
		else $error("output valid without a load");

endmodule
`default_nettype wire

[design/maws_ram.sv]
`default_nettype none
module maws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

[design/maws_ctrl.sv]
`default_nettype none
module maws_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire maws_pkg::stat_t st,
	output maws_pkg::cmd_t      cmd
);
	import maws_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_RDWAIT = 2'd2;
	localparam logic [1:0] S_FILL   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       slot_free;
	logic       out_valid_q;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the output register can take the result
				if (slot_free) begin
					if (st.read_go) begin
						cmd.rd_issue = 1'b1;
						state_d      = S_RDWAIT;
					end else if (st.fill_go) begin
						cmd.fill_start = 1'b1;
						state_d        = S_FILL;
					end else begin
						cmd.exec = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			S_RDWAIT: begin
				cmd.out_ram = 1'b1;
				state_d     = S_IDLE;
			end
			S_FILL: begin
				if (st.fill_done) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.fill_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec || cmd.out_ram) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[design/maws_dp.sv]
`default_nettype none
module maws_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire maws_pkg::cmd_t                cmd,
	output maws_pkg::stat_t                    st,
	input  wire logic [maws_pkg::OP_W-1:0]     op,
	input  wire logic [maws_pkg::AID_W-1:0]    array_id,
	input  wire logic [maws_pkg::EIDX_W-1:0]   element_index,
	input  wire logic [maws_pkg::WORD_W-1:0]   write_value,
	output logic      [maws_pkg::WORD_W-1:0]   result_word,
	output logic                               status_ok
);
	import maws_pkg::*;

	logic [OP_W-1:0]   op_q;
	logic [AID_W-1:0]  id_q;
	logic [EIDX_W-1:0] idx_q;
	logic [WORD_W-1:0] val_q;

	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  len_q [MAX_ARRAYS];
	logic [IDX_W-1:0]  k_q;

	logic [ID_W-1:0]   slot;
	logic [IDX_W-1:0]  idx_lo;
	logic              id_ok;
	logic              idx_neg;
	logic              bank_full;
	logic [LEN_W-1:0]  cur_len;
	logic              in_len;
	logic              wr_ok;
	logic              need_fill;
	logic [LEN_W-1:0]  new_len;

	logic [WORD_W-1:0] res_d;
	logic              ok_d;
	logic              do_create;
	logic              do_write;
	logic              do_clear;

	logic              mem_en;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;

	assign slot      = ID_W'(id_q - AID_W'(1));
	assign idx_lo    = idx_q[IDX_W-1:0];
	assign id_ok     = (id_q != '0) && ({{(AID_W+1-CNT_W){1'b0}}, count_q} >= {1'b0, id_q});
	assign idx_neg   = idx_q[EIDX_W-1];
	assign bank_full = (count_q == CNT_W'(MAX_ARRAYS));
	assign cur_len   = id_ok ? len_q[slot] : '0;
	assign in_len    = !idx_neg && (idx_q < EIDX_W'(cur_len));
	assign wr_ok     = id_ok && !idx_neg && (idx_q < EIDX_W'(MAX_LEN));
	assign need_fill = EIDX_W'(cur_len) < idx_q;
	assign new_len   = LEN_W'(idx_lo) + LEN_W'(1);

	assign st.read_go   = (op_q == OP_READ) && id_ok && in_len;
	assign st.fill_go   = (op_q == OP_WRITE) && wr_ok && need_fill;
	assign st.fill_done = (k_q == idx_lo);

	assign do_create = cmd.exec && (op_q == OP_CREATE) && !bank_full;
	assign do_write  = cmd.exec && (op_q == OP_WRITE) && wr_ok;
	assign do_clear  = cmd.exec && (op_q == OP_CLEAR) && id_ok;

	always_comb begin
		res_d = '0;
		ok_d  = 1'b0;
		case (op_q)
			OP_CREATE: begin
				if (!bank_full) begin
					res_d = WORD_W'(count_q) + WORD_W'(1);
					ok_d  = 1'b1;
				end
			end
			OP_WRITE: begin
				if (wr_ok) begin
					res_d = WORD_W'(1);
					ok_d  = 1'b1;
				end
			end
			OP_SIZE: begin
				if (id_ok) begin
					res_d = WORD_W'(cur_len);
					ok_d  = 1'b1;
				end
			end
			OP_CLEAR: begin
				if (id_ok) begin
					res_d = WORD_W'(1);
					ok_d  = 1'b1;
				end
			end
			default: begin
				// a read that misses, or an unknown op, gives a rejection
				res_d = '0;
				ok_d  = 1'b0;
			end
		endcase
	end

	assign mem_en    = cmd.rd_issue || cmd.fill_step || do_write;
	assign mem_we    = cmd.fill_step || do_write;
	assign mem_addr  = cmd.fill_step ? {slot, k_q} : {slot, idx_lo};
	assign mem_wdata = cmd.fill_step ? '0 : val_q;

	maws_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MEM_DEPTH)
	) u_store (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= op;
			id_q  <= array_id;
			idx_q <= element_index;
			val_q <= write_value;
		end
		if (cmd.fill_start) begin
			k_q <= cur_len[IDX_W-1:0];
		end else if (cmd.fill_step) begin
			k_q <= k_q + IDX_W'(1);
		end
		if (cmd.exec) begin
			result_word <= res_d;
			status_ok   <= ok_d;
		end else if (cmd.out_ram) begin
			result_word <= mem_rdata;
			status_ok   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_ARRAYS; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			if (do_create) begin
				len_q[count_q[ID_W-1:0]] <= '0;
				count_q                  <= count_q + CNT_W'(1);
			end
			if (do_write && !in_len) begin
				len_q[slot] <= new_len;
			end
			if (do_clear) begin
				len_q[slot] <= '0;
			end
		end
	end

endmodule
`default_nettype wire
